@@ design/arv_pkg.sv @@
// ----------------------------------------------------------------------------
// arv_pkg
// Shared types, codes and character helpers of the attestation request
// validator.
// ----------------------------------------------------------------------------
package arv_pkg;

    typedef enum logic [1:0] {
        KIND_HDR  = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_TRL  = 2'd2
    } t_kind;

    localparam logic [7:0] CH_DOT  = 8'h2e;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_Z    = 8'h7a;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_DASH = 8'h2d;

    localparam int PREFIX_LEN   = 4;
    localparam int MIN_NAME_LEN = 5;

    typedef struct packed {
        logic acc_byte;
        logic s1_byte;
        logic s1_trl;
        logic restart;
    } t_cell_ctl;

    function automatic logic [7:0] prefix_char(input logic [1:0] pos);
        logic [7:0] c;
        begin
            case (pos)
                2'd0:    c = 8'h65;
                2'd1:    c = 8'h6e;
                2'd2:    c = 8'h76;
                default: c = CH_DOT;
            endcase
            return c;
        end
    endfunction

    function automatic logic char_allowed(input logic [7:0] b);
        return ((b >= CH_A) && (b <= CH_Z)) || ((b >= CH_0) && (b <= CH_9)) ||
               (b == CH_DASH);
    endfunction

endpackage

@@ design/arv_cell.sv @@
// ----------------------------------------------------------------------------
// arv_cell
// One record slot: stores a name row and its length, tracks whether the
// current name still equals it, and passes the duplicate flag down the chain.
// ----------------------------------------------------------------------------
module arv_cell #(
    parameter int ENV_MAX_LEN = 64,
    parameter int IDX         = 0,
    parameter int AW          = 6,
    parameter int PW          = 7,
    parameter int RW          = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  arv_pkg::t_cell_ctl i_ctl,
    input  logic [RW-1:0]      i_acc_idx,
    input  logic [PW-1:0]      i_acc_pos,
    input  logic [7:0]         i_acc_byte,
    input  logic [RW-1:0]      i_s1_idx,
    input  logic [PW-1:0]      i_s1_pos,
    input  logic [7:0]         i_s1_byte,
    input  logic               i_dup,
    output logic               o_dup
);
    import arv_pkg::*;

    logic [7:0]    r_mem [ENV_MAX_LEN];
    logic [7:0]    r_rd;
    logic [PW-1:0] r_len;
    logic          r_match;
    logic          n_match;
    logic          older;
    logic          wr_en;
    logic          miss;

    assign older = RW'(IDX) < i_s1_idx;
    assign wr_en = i_ctl.acc_byte && (i_acc_idx == RW'(IDX)) &&
                   (i_acc_pos < PW'(ENV_MAX_LEN));
    assign miss  = (i_s1_pos >= r_len) || (i_s1_pos >= PW'(ENV_MAX_LEN)) ||
                   (r_rd != i_s1_byte);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_acc_pos[AW-1:0]] <= i_acc_byte;
        end
        if (i_ctl.acc_byte) begin
            r_rd <= r_mem[i_acc_pos[AW-1:0]];
        end
        if (i_ctl.s1_trl && (i_s1_idx == RW'(IDX))) begin
            r_len <= i_s1_pos;
        end
    end

    always_comb begin
        n_match = r_match;
        if (i_ctl.restart) begin
            n_match = 1'b1;
        end else if (i_ctl.s1_byte && older && miss) begin
            n_match = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b1;
        end else begin
            r_match <= n_match;
        end
    end

    assign o_dup = i_dup || (i_ctl.s1_trl && older && r_match && (r_len == i_s1_pos));

endmodule

@@ design/attestation_request_validator_core.sv @@
// ----------------------------------------------------------------------------
// attestation_request_validator_core
// Checks a streamed attestation request (header, name bytes, trailers) and
// gives one ok/bad verdict per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (i_valid/o_stall) carry a header, then per record its name
//   bytes and a trailer. Output words (o_valid/i_stall) carry o_status,
//   0 for ok and 1 for bad argument.
//   A verdict word follows a failing header or the last announced trailer;
//   other words give none.
//   Throughput is one input word per cycle while o_stall is low. An accepted
//   word is registered in the compare stage, a name byte together with
//   every cell's registered read of its name row; the compare stage then
//   decides and registers the verdict in the output register.
//   The cells sit in a chain, one per record; each cell of a record before
//   the current one compares its stored name with the current byte in
//   parallel, and the duplicate flag ripples along the chain at each trailer.
//   While a verdict waits under i_stall, input words are still taken until
//   the compare stage holds a word of its own, then o_stall rises.
//   Reset (i_rst_n low, synchronous) drops any pending request and any
//   waiting verdict; no clearing pass is needed.
// ----------------------------------------------------------------------------
module attestation_request_validator_core #(
    parameter int          MAX_RECORDS     = 8,
    parameter int          ENV_MAX_LEN     = 64,
    parameter int          NONCE_LEN       = 32,
    parameter int          DIGEST_LEN      = 48,
    parameter logic [31:0] REQUEST_VERSION = 32'd1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_version,
    input  logic        i_nonce_present,
    input  logic [7:0]  i_nonce_len,
    input  logic [7:0]  i_rec_count,
    input  logic [7:0]  i_env_byte,
    input  logic        i_env_present,
    input  logic        i_digest_present,
    input  logic [7:0]  i_digest_len,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_status
);
    import arv_pkg::*;

    localparam int RW = $clog2(MAX_RECORDS + 1);
    localparam int PW = $clog2(ENV_MAX_LEN + 2);
    localparam int AW = $clog2(ENV_MAX_LEN);

    // front end
    logic [RW-1:0] r_rec, n_rec;
    logic [RW-1:0] r_exp, n_exp;
    logic [PW-1:0] r_pos, n_pos;
    logic          r_prev_dot, n_prev_dot;
    logic          r_active, n_active;

    // compare stage
    logic          r_s1_valid, n_s1_valid;
    t_kind         r_s1_kind, n_s1_kind;
    logic          r_s1_bad, n_s1_bad;
    logic          r_s1_last, n_s1_last;
    logic [7:0]    r_s1_byte, n_s1_byte;
    logic [PW-1:0] r_s1_pos, n_s1_pos;
    logic [RW-1:0] r_s1_idx, n_s1_idx;

    // back end
    logic          r_failed, n_failed;
    logic          r_out_valid, n_out_valid;
    logic          r_out_status, n_out_status;

    logic          out_free;
    logic          s1_go;
    logic          acc;
    logic          hdr_ok;
    logic          byte_bad;
    logic          trl_bad;
    logic          last_rec;
    logic [RW:0]   rec_inc;
    t_cell_ctl     cell_ctl;
    logic [MAX_RECORDS:0] dup_chain;

    assign out_free = !r_out_valid || !i_stall;
    assign s1_go    = r_s1_valid && out_free;
    assign o_stall  = r_s1_valid && !out_free;
    assign acc      = i_valid && !o_stall;

    assign hdr_ok = (i_version == REQUEST_VERSION) && i_nonce_present &&
                    (i_nonce_len == 8'(NONCE_LEN)) && (i_rec_count != 8'd0) &&
                    (i_rec_count <= 8'(MAX_RECORDS));

    always_comb begin
        if (r_pos < PW'(PREFIX_LEN)) begin
            byte_bad = i_env_byte != prefix_char(r_pos[1:0]);
        end else if (i_env_byte == CH_DOT) begin
            byte_bad = r_prev_dot;
        end else begin
            byte_bad = !char_allowed(i_env_byte);
        end
    end

    assign trl_bad = !i_env_present || !i_digest_present ||
                     (i_digest_len != 8'(DIGEST_LEN)) ||
                     (r_pos < PW'(MIN_NAME_LEN)) || (r_pos > PW'(ENV_MAX_LEN)) ||
                     r_prev_dot;

    assign rec_inc  = {1'b0, r_rec} + (RW+1)'(1);
    assign last_rec = rec_inc >= {1'b0, r_exp};

    always_comb begin
        n_rec      = r_rec;
        n_exp      = r_exp;
        n_pos      = r_pos;
        n_prev_dot = r_prev_dot;
        n_active   = r_active;
        n_s1_valid = s1_go ? 1'b0 : r_s1_valid;
        n_s1_kind  = r_s1_kind;
        n_s1_bad   = r_s1_bad;
        n_s1_last  = r_s1_last;
        n_s1_byte  = r_s1_byte;
        n_s1_pos   = r_s1_pos;
        n_s1_idx   = r_s1_idx;
        if (acc) begin
            n_s1_byte = i_env_byte;
            n_s1_pos  = r_pos;
            n_s1_idx  = r_rec;
            n_s1_last = last_rec;
            case (i_kind)
                KIND_HDR: begin
                    n_rec      = '0;
                    n_pos      = '0;
                    n_prev_dot = 1'b0;
                    n_active   = hdr_ok;
                    n_exp      = hdr_ok ? i_rec_count[RW-1:0] : '0;
                    n_s1_valid = 1'b1;
                    n_s1_kind  = KIND_HDR;
                    n_s1_bad   = !hdr_ok;
                end
                KIND_BYTE: begin
                    if (r_active) begin
                        if (r_pos <= PW'(ENV_MAX_LEN)) begin
                            n_pos = r_pos + PW'(1);
                        end
                        n_prev_dot = i_env_byte == CH_DOT;
                        n_s1_valid = 1'b1;
                        n_s1_kind  = KIND_BYTE;
                        n_s1_bad   = byte_bad;
                    end
                end
                KIND_TRL: begin
                    if (r_active) begin
                        n_rec      = rec_inc[RW-1:0];
                        n_pos      = '0;
                        n_prev_dot = 1'b0;
                        if (last_rec) begin
                            n_active = 1'b0;
                        end
                        n_s1_valid = 1'b1;
                        n_s1_kind  = KIND_TRL;
                        n_s1_bad   = trl_bad;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign cell_ctl.acc_byte = acc && (i_kind == KIND_BYTE) && r_active;
    assign cell_ctl.s1_byte  = s1_go && (r_s1_kind == KIND_BYTE);
    assign cell_ctl.s1_trl   = s1_go && (r_s1_kind == KIND_TRL);
    assign cell_ctl.restart  = s1_go && ((r_s1_kind == KIND_HDR) || (r_s1_kind == KIND_TRL));

    assign dup_chain[0] = 1'b0;

    for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
        arv_cell #(
            .ENV_MAX_LEN (ENV_MAX_LEN),
            .IDX         (g),
            .AW          (AW),
            .PW          (PW),
            .RW          (RW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (cell_ctl),
            .i_acc_idx  (r_rec),
            .i_acc_pos  (r_pos),
            .i_acc_byte (i_env_byte),
            .i_s1_idx   (r_s1_idx),
            .i_s1_pos   (r_s1_pos),
            .i_s1_byte  (r_s1_byte),
            .i_dup      (dup_chain[g]),
            .o_dup      (dup_chain[g+1])
        );
    end

    always_comb begin
        n_failed     = r_failed;
        n_out_valid  = out_free ? 1'b0 : r_out_valid;
        n_out_status = r_out_status;
        if (s1_go) begin
            case (r_s1_kind)
                KIND_HDR: begin
                    n_failed = 1'b0;
                    if (r_s1_bad) begin
                        n_out_valid  = 1'b1;
                        n_out_status = 1'b1;
                    end
                end
                KIND_BYTE: begin
                    n_failed = r_failed || r_s1_bad;
                end
                KIND_TRL: begin
                    n_failed = r_failed || r_s1_bad || dup_chain[MAX_RECORDS];
                    if (r_s1_last) begin
                        n_out_valid  = 1'b1;
                        n_out_status = n_failed;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec       <= '0;
            r_exp       <= '0;
            r_pos       <= '0;
            r_prev_dot  <= 1'b0;
            r_active    <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rec       <= n_rec;
            r_exp       <= n_exp;
            r_pos       <= n_pos;
            r_prev_dot  <= n_prev_dot;
            r_active    <= n_active;
            r_s1_valid  <= n_s1_valid;
            r_failed    <= n_failed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_kind    <= n_s1_kind;
        r_s1_bad     <= n_s1_bad;
        r_s1_last    <= n_s1_last;
        r_s1_byte    <= n_s1_byte;
        r_s1_pos     <= n_s1_pos;
        r_s1_idx     <= n_s1_idx;
        r_out_status <= n_out_status;
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;

endmodule
